// ===== hw/rtl/psns_pkg.sv =====
// Package for the pixel store nearest-neighbor scaler.
// Holds the item structs, widths and operation / register codes.
// No dependencies; every other file imports it.
package psns_pkg;

  localparam int MAX_DIM     = 256;
  localparam int COORD_W     = $clog2(MAX_DIM);
  localparam int SIZE_W      = $clog2(MAX_DIM) + 1;
  localparam int ADDR_W      = 2 * COORD_W;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int PIX_W       = 32;
  localparam int CFG_IDX_W   = 3;

  localparam logic [PIX_W-1:0] MASK24 = 32'h00FF_FFFF;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SCALED = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_USE_ALPHA  = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic [COORD_W-1:0] item_x;
    logic [COORD_W-1:0] item_y;
    logic [PIX_W-1:0]   pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             out_of_range;
  } out_item_t;

endpackage

// ===== hw/rtl/psns_div.sv =====
// Shared axis mapper: (2t+1)*src_size / (2*dst_size), one quotient bit a cycle.
// Restoring divider after a single registered multiply at start.
// Depends on psns_pkg.
module psns_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [psns_pkg::COORD_W-1:0]   coord,
  input  logic [psns_pkg::SIZE_W-1:0]    tsize,
  input  logic [psns_pkg::SIZE_W-1:0]    ssize,
  output logic                           done,
  output logic [psns_pkg::SIZE_W-1:0]    quot
);
  import psns_pkg::*;

  localparam int QUOT_W = SIZE_W;
  localparam int CNT_W  = $clog2(QUOT_W + 1);

  logic [2*SIZE_W-1:0] prod;
  logic [SIZE_W-1:0]   rem_r;
  logic [QUOT_W-1:0]   low_r;
  logic [SIZE_W:0]     den_r;
  logic [QUOT_W-1:0]   quot_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                running_r;
  logic                done_r;
  logic [SIZE_W:0]     trial;
  logic [SIZE_W:0]     diff;
  logic                ge;

  assign prod  = (2*SIZE_W)'({coord, 1'b1}) * (2*SIZE_W)'(ssize);
  assign trial = {rem_r, low_r[QUOT_W-1]};
  assign ge    = (trial >= den_r);
  assign diff  = trial - den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // quotient stays below 2^QUOT_W, so the top part starts below den
        rem_r     <= prod[2*SIZE_W-1:QUOT_W];
        low_r     <= prod[QUOT_W-1:0];
        den_r     <= {tsize, 1'b0};
        quot_r    <= '0;
        cnt_r     <= '0;
        running_r <= 1'b1;
      end else if (running_r) begin
        rem_r  <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        low_r  <= low_r << 1;
        quot_r <= {quot_r[QUOT_W-2:0], ge};
        cnt_r  <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUOT_W - 1)) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== hw/rtl/psns_store.sv =====
// Pixel store: single-port memory, one write or one read a cycle.
// Read data is registered. Contents are undefined until written.
// Depends on psns_pkg.
module psns_store (
  input  logic                          clk,
  input  logic                          we,
  input  logic                          re,
  input  logic [psns_pkg::ADDR_W-1:0]   addr,
  input  logic [psns_pkg::PIX_W-1:0]    wdata,
  output logic [psns_pkg::PIX_W-1:0]    rdata
);
  import psns_pkg::*;

  logic [PIX_W-1:0] mem [STORE_DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pixel_store_nearest_scaler_unit.sv =====
// Top level of the pixel store nearest-neighbor scaler.
// Sequencer, configuration registers and address unit; uses psns_div,
// psns_store and psns_pkg.
//
//   channel   ports                        transfer
//   input     start, busy, in_item         start high while busy low
//   result    out_strobe, out_item         one cycle, out_strobe high
//   config    cfg_we, cfg_index, cfg_wdata cfg_we high
//
// Source write steps through decode, address and store access; source read adds a wait
// state, with the result strobed on the cycle after. Scaled read maps x, then y, through
// the shared divider (9 quotient bits per axis, then done) before the address step.
// Target coordinate out of range ends the item at decode; source out of range at address.
// Reset sets sizes to 256 and 32-bit mode; store contents stay undefined.
// The receiver cannot stall; each result shows for one cycle only.
module pixel_store_nearest_scaler_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  psns_pkg::in_item_t                in_item,
  output logic                              out_strobe,
  output psns_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [psns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psns_pkg::SIZE_W-1:0]       cfg_wdata
);
  import psns_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_MAP_X, ST_MAP_Y, ST_ADDR, ST_ACCESS, ST_WAIT
  } state_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
    return (r > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : r;
  endfunction

  state_t              state_r;
  logic [1:0]          op_r;
  logic [COORD_W-1:0]  x_r;
  logic [COORD_W-1:0]  y_r;
  logic [PIX_W-1:0]    val_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [SIZE_W-1:0]   src_w_r;
  logic [SIZE_W-1:0]   src_h_r;
  logic [SIZE_W-1:0]   dst_w_r;
  logic [SIZE_W-1:0]   dst_h_r;
  logic                alpha_r;
  logic                out_strobe_r;
  out_item_t           out_item_r;

  logic [SIZE_W-1:0]   sw_eff;
  logic [SIZE_W-1:0]   sh_eff;
  logic [SIZE_W-1:0]   dw_eff;
  logic [SIZE_W-1:0]   dh_eff;
  logic                tgt_bad;
  logic                src_bad;
  logic [COORD_W+SIZE_W-1:0] addr_prod;
  logic [COORD_W+SIZE_W-1:0] addr_sum;

  logic                div_start;
  logic [COORD_W-1:0]  div_coord;
  logic [SIZE_W-1:0]   div_tsize;
  logic [SIZE_W-1:0]   div_ssize;
  logic                div_done;
  logic [SIZE_W-1:0]   div_quot;

  logic                mem_we;
  logic                mem_re;
  logic [PIX_W-1:0]    mem_wdata;
  logic [PIX_W-1:0]    mem_rdata;

  assign sw_eff = eff_size(src_w_r);
  assign sh_eff = eff_size(src_h_r);
  assign dw_eff = eff_size(dst_w_r);
  assign dh_eff = eff_size(dst_h_r);

  assign tgt_bad = ({1'b0, x_r} >= dw_eff) || ({1'b0, y_r} >= dh_eff);
  assign src_bad = ({1'b0, x_r} >= sw_eff) || ({1'b0, y_r} >= sh_eff);

  assign addr_prod = (COORD_W + SIZE_W)'(y_r) * (COORD_W + SIZE_W)'(sw_eff);
  assign addr_sum  = addr_prod + (COORD_W + SIZE_W)'(x_r);

  always_comb begin
    div_start = 1'b0;
    div_coord = x_r;
    div_tsize = dw_eff;
    div_ssize = sw_eff;
    case (state_r)
      ST_DECODE: begin
        div_start = (op_r == OP_SCALED) && !tgt_bad;
      end
      ST_MAP_X: begin
        div_start = div_done;
        div_coord = y_r;
        div_tsize = dh_eff;
        div_ssize = sh_eff;
      end
      default: ;
    endcase
  end

  assign mem_we    = (state_r == ST_ACCESS) && (op_r == OP_WRITE);
  assign mem_re    = (state_r == ST_ACCESS) && (op_r != OP_WRITE);
  assign mem_wdata = alpha_r ? val_r : (val_r & MASK24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      src_w_r      <= SIZE_W'(MAX_DIM);
      src_h_r      <= SIZE_W'(MAX_DIM);
      dst_w_r      <= SIZE_W'(MAX_DIM);
      dst_h_r      <= SIZE_W'(MAX_DIM);
      alpha_r      <= 1'b1;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_w_r <= cfg_wdata;
          REG_SRC_HEIGHT: src_h_r <= cfg_wdata;
          REG_DST_WIDTH:  dst_w_r <= cfg_wdata;
          REG_DST_HEIGHT: dst_h_r <= cfg_wdata;
          REG_USE_ALPHA:  alpha_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (start) begin
            op_r    <= in_item.operation;
            x_r     <= in_item.item_x;
            y_r     <= in_item.item_y;
            val_r   <= in_item.pixel_value;
            state_r <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          case (op_r)
            OP_WRITE, OP_READ: state_r <= ST_ADDR;
            OP_SCALED: begin
              if (tgt_bad) begin
                out_item_r.pixel_out    <= '0;
                out_item_r.out_of_range <= 1'b1;
                out_strobe_r            <= 1'b1;
                state_r                 <= ST_IDLE;
              end else begin
                state_r <= ST_MAP_X;
              end
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_MAP_X: begin
          if (div_done) begin
            x_r     <= div_quot[COORD_W-1:0];
            state_r <= ST_MAP_Y;
          end
        end
        ST_MAP_Y: begin
          if (div_done) begin
            y_r     <= div_quot[COORD_W-1:0];
            state_r <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          if (src_bad) begin
            // drop writes outside the image; flag reads
            if (op_r != OP_WRITE) begin
              out_item_r.pixel_out    <= '0;
              out_item_r.out_of_range <= 1'b1;
              out_strobe_r            <= 1'b1;
            end
            state_r <= ST_IDLE;
          end else begin
            addr_r  <= addr_sum[ADDR_W-1:0];
            state_r <= ST_ACCESS;
          end
        end
        ST_ACCESS: begin
          state_r <= (op_r == OP_WRITE) ? ST_IDLE : ST_WAIT;
        end
        ST_WAIT: begin
          out_item_r.pixel_out    <= alpha_r ? mem_rdata : (mem_rdata & MASK24);
          out_item_r.out_of_range <= 1'b0;
          out_strobe_r            <= 1'b1;
          state_r                 <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  psns_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .coord (div_coord),
    .tsize (div_tsize),
    .ssize (div_ssize),
    .done  (div_done),
    .quot  (div_quot)
  );

  psns_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (addr_r),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ===== hw/rtl/psns_checker.sv =====
// Port-level checker for the pixel store nearest-neighbor scaler.
// Bound to the top level below; depends on psns_pkg.
module psns_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  out_strobe,
  input  psns_pkg::out_item_t   out_item
);
  import psns_pkg::*;

  // an accepted item always occupies the block for at least a cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  // results come only once the item is finished
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobed while busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two results in consecutive cycles");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.out_of_range |-> out_item.pixel_out == '0)
    else $error("out-of-range result carries a nonzero pixel");

endmodule

bind pixel_store_nearest_scaler_unit psns_checker u_psns_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// ===== tb/sv/pixel_store_nearest_scaler_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for pixel_store_nearest_scaler_unit: pixel writes, source reads and
// scaled reads are driven with random gaps and checked against an in-bench pixel model.
// Depends on psns_pkg and the unit RTL only.
module pixel_store_nearest_scaler_unit_test;
  import psns_pkg::*;

  localparam int RUN_LIMIT  = 600000;
  localparam int RAND_ITEMS = 550;
  localparam int SETTLE_CYC = 30;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 start      = 1'b0;
  logic                 busy;
  in_item_t             in_item    = '0;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [SIZE_W-1:0]    cfg_wdata  = '0;

  // register copies as written through the port
  logic [SIZE_W-1:0] src_w_reg = 9'd256;
  logic [SIZE_W-1:0] src_h_reg = 9'd256;
  logic [SIZE_W-1:0] dst_w_reg = 9'd256;
  logic [SIZE_W-1:0] dst_h_reg = 9'd256;
  logic              alpha_reg = 1'b1;

  logic [PIX_W-1:0] pix_img [STORE_DEPTH];
  bit               wr_plan [STORE_DEPTH];
  in_item_t         pixel_ops_q [$];
  out_item_t        read_results_q [$];

  int cycle_cnt = 0;
  int err_cnt   = 0;
  int idle_left = 0;
  int n_queued  = 0;
  bit took_item = 1'b0;
  bit gap_on    = 1'b1;

  pixel_store_nearest_scaler_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int clip_size(logic [SIZE_W-1:0] v);
    return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic int map_axis(int t, int tsz, int ssz);
    return ((2 * t + 1) * ssz) / (2 * tsz);
  endfunction

  // Expected outcome of one accepted item; reads push one result.
  function automatic void apply_pixel_op(in_item_t it);
    int        sw, sh, dw, dh, px, py;
    bit        bad;
    out_item_t res;
    sw  = clip_size(src_w_reg);
    sh  = clip_size(src_h_reg);
    dw  = clip_size(dst_w_reg);
    dh  = clip_size(dst_h_reg);
    px  = int'(it.item_x);
    py  = int'(it.item_y);
    bad = 1'b0;
    case (it.operation)
      OP_WRITE: begin
        if (px < sw && py < sh)
          pix_img[ADDR_W'(py * sw + px)] = alpha_reg ? it.pixel_value
                                                     : (it.pixel_value & MASK24);
        return;
      end
      OP_NONE: return;
      OP_SCALED: begin
        if (px >= dw || py >= dh) begin
          bad = 1'b1;
        end else begin
          px = map_axis(px, dw, sw);
          py = map_axis(py, dh, sh);
        end
      end
      default: ;
    endcase
    if (!bad && (px >= sw || py >= sh))
      bad = 1'b1;
    res.out_of_range = bad;
    if (bad)
      res.pixel_out = '0;
    else
      res.pixel_out = alpha_reg ? pix_img[ADDR_W'(py * sw + px)]
                                : (pix_img[ADDR_W'(py * sw + px)] & MASK24);
    read_results_q.push_back(res);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 75) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 30);
    return $urandom_range(31, 80);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)  return '0;
    if (r < 8)  return 9'd256;
    if (r < 12) return SIZE_W'($urandom_range(257, 511));
    if (r < 20) return 9'd1;
    if (r < 80) return SIZE_W'($urandom_range(2, 16));
    return SIZE_W'($urandom_range(17, 255));
  endfunction

  // Mostly inside a nonzero limit, edges favored; the rest beyond it, or anywhere at MAX_DIM.
  function automatic int pick_coord(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (lim > 0 && r < 88) begin
      if (r < 8)  return 0;
      if (r < 16) return lim - 1;
      return $urandom_range(0, lim - 1);
    end
    if (lim < MAX_DIM) return $urandom_range(lim, MAX_DIM - 1);
    return $urandom_range(0, MAX_DIM - 1);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic void queue_op(logic [1:0] op, int x, int y, logic [PIX_W-1:0] val);
    in_item_t it;
    int       sw, sh;
    sw             = clip_size(src_w_reg);
    sh             = clip_size(src_h_reg);
    it.operation   = op;
    it.item_x      = COORD_W'(x);
    it.item_y      = COORD_W'(y);
    it.pixel_value = val;
    if (op == OP_WRITE && x < sw && y < sh)
      wr_plan[ADDR_W'(y * sw + x)] = 1'b1;
    pixel_ops_q.push_back(it);
    n_queued++;
  endfunction

  // Store a pixel first where a read would hit an entry never written.
  function automatic void ensure_written(int x, int y);
    int sw, sh;
    sw = clip_size(src_w_reg);
    sh = clip_size(src_h_reg);
    if (x < sw && y < sh && !wr_plan[ADDR_W'(y * sw + x)])
      queue_op(OP_WRITE, x, y, rand_pixel());
  endfunction

  function automatic void queue_read(int x, int y);
    ensure_written(x, y);
    queue_op(OP_READ, x, y, rand_pixel());
  endfunction

  function automatic void queue_scaled(int x, int y);
    int sw, sh, dw, dh;
    sw = clip_size(src_w_reg);
    sh = clip_size(src_h_reg);
    dw = clip_size(dst_w_reg);
    dh = clip_size(dst_h_reg);
    if (x < dw && y < dh)
      ensure_written(map_axis(x, dw, sw), map_axis(y, dh, sh));
    queue_op(OP_SCALED, x, y, rand_pixel());
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hold until every item is taken and every read has answered, then let writes settle.
  task automatic wait_drained();
    while (pixel_ops_q.size() != 0 || start || busy || read_results_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Monitor: register copies, result check, input transfer.
  always @(posedge clk) begin
    cycle_cnt++;
    if (!rst_n) begin
      src_w_reg = 9'd256;
      src_h_reg = 9'd256;
      dst_w_reg = 9'd256;
      dst_h_reg = 9'd256;
      alpha_reg = 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_w_reg = cfg_wdata;
          REG_SRC_HEIGHT: src_h_reg = cfg_wdata;
          REG_DST_WIDTH:  dst_w_reg = cfg_wdata;
          REG_DST_HEIGHT: dst_h_reg = cfg_wdata;
          REG_USE_ALPHA:  alpha_reg = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (read_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got pixel_out %h out_of_range %b",
                   $time, out_item.pixel_out, out_item.out_of_range);
          err_cnt++;
        end else begin
          if (out_item.pixel_out !== read_results_q[0].pixel_out) begin
            $display("%0t: pixel_out expected %h, got %h",
                     $time, read_results_q[0].pixel_out, out_item.pixel_out);
            err_cnt++;
          end
          if (out_item.out_of_range !== read_results_q[0].out_of_range) begin
            $display("%0t: out_of_range expected %b, got %b",
                     $time, read_results_q[0].out_of_range, out_item.out_of_range);
            err_cnt++;
          end
          void'(read_results_q.pop_front());
        end
      end
      if (start && !busy) begin
        apply_pixel_op(in_item);
        took_item = 1'b1;
      end
    end
  end

  // Driver: drop start after a transfer, idle for the chosen gap, then launch the next item.
  always @(negedge clk) begin
    logic nxt_start;
    nxt_start = start;
    if (took_item) begin
      nxt_start = 1'b0;
      took_item = 1'b0;
    end
    if (rst_n && !nxt_start) begin
      if (idle_left > 0) begin
        idle_left--;
      end else if (pixel_ops_q.size() != 0) begin
        in_item   <= pixel_ops_q.pop_front();
        nxt_start = 1'b1;
        idle_left = gap_on ? pick_gap() : 0;
      end
    end
    start <= nxt_start;
  end

  initial begin
    while (cycle_cnt < RUN_LIMIT) @(posedge clk);
    $display("pixel_store_nearest_scaler_unit_test: errors");
    $finish;
  end

  initial begin
    int x, y, r, n_phase, sw, sh, dw, dh;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // full-size defaults: corners, extreme pixels, identity scaling, unused code
    queue_op(OP_WRITE, 0, 0, 32'hFFFF_FFFF);
    queue_op(OP_WRITE, 255, 255, 32'h0000_0000);
    queue_op(OP_WRITE, 255, 0, 32'hA5A5_5A5A);
    queue_op(OP_WRITE, 0, 255, 32'h1234_5678);
    queue_read(0, 0);
    queue_read(255, 255);
    queue_read(255, 0);
    queue_read(0, 255);
    queue_scaled(0, 0);
    queue_scaled(255, 255);
    queue_op(OP_NONE, 17, 99, 32'hDEAD_BEEF);
    wait_drained();

    // zero width, oversized height, junk indexes, alpha from bit 0 only
    cfg_write(REG_SRC_WIDTH, 9'd0);
    cfg_write(REG_SRC_HEIGHT, 9'd300);
    cfg_write(REG_DST_WIDTH, 9'd3);
    cfg_write(REG_DST_HEIGHT, 9'd511);
    cfg_write(REG_USE_ALPHA, 9'h002);
    cfg_write(3'd5, 9'h1FF);
    cfg_write(3'd6, 9'h000);
    cfg_write(3'd7, 9'h155);
    queue_op(OP_WRITE, 0, 0, 32'hCAFE_F00D);
    queue_read(0, 0);
    queue_scaled(1, 1);
    queue_scaled(3, 0);
    wait_drained();

    // small image in 24-bit mode, edges and out-of-range accesses
    cfg_write(REG_SRC_WIDTH, 9'd5);
    cfg_write(REG_SRC_HEIGHT, 9'd3);
    cfg_write(REG_DST_WIDTH, 9'd1);
    cfg_write(REG_DST_HEIGHT, 9'd7);
    cfg_write(REG_USE_ALPHA, 9'h000);
    queue_op(OP_WRITE, 4, 2, 32'hFFFF_FFFF);
    queue_read(4, 2);
    queue_op(OP_WRITE, 5, 0, 32'h0BAD_0BAD);
    queue_read(5, 0);
    queue_read(0, 3);
    queue_scaled(0, 6);
    queue_scaled(1, 0);
    wait_drained();

    // back to 32-bit mode over what was stored in 24-bit mode
    cfg_write(REG_USE_ALPHA, 9'h103);
    queue_read(4, 2);
    queue_op(OP_WRITE, 3, 1, 32'hFFFF_FFFF);
    queue_read(3, 1);

    while (n_queued < RAND_ITEMS) begin
      wait_drained();
      if ($urandom_range(0, 9) < 3) begin
        // keep the source geometry so stored pixels are read back in the other mode
        cfg_write(REG_USE_ALPHA, {{(SIZE_W-1){1'b0}}, ~alpha_reg});
        cfg_write(REG_DST_WIDTH, pick_size());
        cfg_write(REG_DST_HEIGHT, pick_size());
      end else begin
        cfg_write(REG_SRC_WIDTH, pick_size());
        cfg_write(REG_SRC_HEIGHT, pick_size());
        cfg_write(REG_DST_WIDTH, pick_size());
        cfg_write(REG_DST_HEIGHT, pick_size());
        cfg_write(REG_USE_ALPHA, SIZE_W'($urandom_range(0, 511)));
      end
      sw      = clip_size(src_w_reg);
      sh      = clip_size(src_h_reg);
      dw      = clip_size(dst_w_reg);
      dh      = clip_size(dst_h_reg);
      gap_on  = ($urandom_range(0, 3) != 0);
      n_phase = $urandom_range(25, 60);
      repeat (n_phase) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          x = pick_coord(sw);
          y = pick_coord(sh);
          queue_op(OP_WRITE, x, y, rand_pixel());
        end else if (r < 60) begin
          queue_read(pick_coord(sw), pick_coord(sh));
        end else if (r < 96) begin
          queue_scaled(pick_coord(dw), pick_coord(dh));
        end else begin
          queue_op(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
        end
      end
    end

    wait_drained();
    if (err_cnt == 0)
      $display("pixel_store_nearest_scaler_unit_test: clean");
    else
      $display("pixel_store_nearest_scaler_unit_test: errors");
    $finish;
  end

endmodule
